// ----- sv/gbd_pkg.sv -----
// ----------------------------------------------------------------------------
// gbd_pkg
// Shared types, constants and register codes for the 5x5 blur / decimate unit.
// ----------------------------------------------------------------------------
package gbd_pkg;

  // default sizes
  localparam int MAX_LINE_DEF = 512;
  localparam int MAX_HEIGHT   = 4096;
  localparam int KERNEL_SIZE  = 5;
  localparam int HALF_K       = KERNEL_SIZE / 2;
  localparam int MIN_SIZE     = 5;

  // fixed field and register widths
  localparam int PIX_W   = 8;
  localparam int COL_W   = 10;
  localparam int ROW_W   = 13;
  localparam int TAP_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CIDX_W  = 3;
  localparam int KIDX_W  = 3;
  localparam int WGT_W   = 2 * TAP_W;
  localparam int PROD_W  = WGT_W + PIX_W;
  localparam int ACC_W   = PROD_W + 5;

  // register reset values
  localparam logic [COL_W-1:0] FRAME_WIDTH_RST  = COL_W'(256);
  localparam logic [ROW_W-1:0] FRAME_HEIGHT_RST = ROW_W'(256);
  localparam logic [TAP_W-1:0] TAP_OUTER_RST    = TAP_W'(3571);
  localparam logic [TAP_W-1:0] TAP_INNER_RST    = TAP_W'(16004);
  localparam logic [TAP_W-1:0] TAP_CENTER_RST   = TAP_W'(26386);

  // register indexes
  typedef enum logic [CIDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_DECIMATE     = 3'd2,
    REG_TAP_OUTER    = 3'd3,
    REG_TAP_INNER    = 3'd4,
    REG_TAP_CENTER   = 3'd5
  } reg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_STEP,
    S_DIV,
    S_ACC,
    S_WAIT,
    S_OUT
  } state_t;

  // request payloads
  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             drain;
  } pix_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_frame;
  } res_req_t;

endpackage

// ----- sv/gaussian_blur_5x5_decimate_unit.sv -----
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_decimate_unit
// 5x5 Gaussian blur over a raster pixel stream, optional 2:1 decimation.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+------------------------------
//  pixel    | pixel_valid  | pixel_stall  | pixel_data  (pixel_in, drain)
//  result   | result_valid | result_stall | result_data (pixel_out, eof)
//  config   | cfg_write    | -            | cfg_index, cfg_data
//
//  An item that gives no result is accepted, then updates the line store.
//  An item that gives a result goes on from there: a radix-2 divider finds
//  the output row and column, then the 25 window pixels are read one per
//  cycle from the line store's single read port, the multiply pipeline
//  empties and the result register is loaded once it is free.
//  After reset all 4*MAX_LINE+8 line store entries are cleared with pixel_stall
//  high. A waiting result holds its register; the next item is still taken.
// ----------------------------------------------------------------------------
module gaussian_blur_5x5_decimate_unit #(
  parameter int MAX_LINE = gbd_pkg::MAX_LINE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pixel_valid,
  output logic                         pixel_stall,
  input  gbd_pkg::pix_req_t            pixel_data,
  output logic                         result_valid,
  input  logic                         result_stall,
  output gbd_pkg::res_req_t            result_data,
  input  logic                         cfg_write,
  input  logic [gbd_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [gbd_pkg::CFG_W-1:0]    cfg_data
);

  localparam int DEPTH  = 4 * MAX_LINE + 8;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int LINE_W = $clog2(MAX_LINE + 1);
  localparam int DLY_W  = LINE_W + 2;
  localparam int TOT_W  = LINE_W + gbd_pkg::ROW_W;
  localparam int SLOT_W = TOT_W + 1;
  localparam int DCNT_W = $clog2(SLOT_W + 1);
  localparam int CLMP_W = 16;
  localparam int KLAST  = gbd_pkg::KERNEL_SIZE - 1;

  gbd_pkg::state_t state, state_next;

  // configuration registers
  logic [gbd_pkg::COL_W-1:0] frame_width;
  logic [gbd_pkg::ROW_W-1:0] frame_height;
  logic                      decimate_enable;
  logic [gbd_pkg::TAP_W-1:0] tap_outer, tap_inner, tap_center;

  // derived frame geometry
  logic [CLMP_W-1:0] w_clamp, h_clamp;
  logic [LINE_W-1:0] w_q, ow_q;
  logic [gbd_pkg::ROW_W-1:0] h_q, oh_q;
  logic [TOT_W-1:0]  total_q;
  logic [DLY_W-1:0]  delay_q;

  // stream position
  logic [gbd_pkg::COL_W-1:0] column_count;
  logic [gbd_pkg::ROW_W-1:0] row_count;
  logic [SLOT_W-1:0]         slot_count;
  logic [ADDR_W-1:0]         slot_mod;
  logic                      input_done;

  // latched request
  logic [gbd_pkg::PIX_W-1:0] px_q;
  logic                      drain_q;

  // clearing pass
  logic [ADDR_W-1:0] clr_addr;

  // step decisions
  logic                      start_new, keep, push, res_hit, last_col, last_row;
  logic [gbd_pkg::COL_W-1:0] col_e;
  logic [gbd_pkg::ROW_W-1:0] row_e;
  logic [SLOT_W-1:0]         slot_e, slot_n, k_n;
  logic [ADDR_W-1:0]         smod_e, smod_n;
  logic [ADDR_W:0]           back_n, base_addr;

  // divider
  logic [SLOT_W-1:0] div_num;
  logic [LINE_W-1:0] rem;
  logic [LINE_W:0]   rem_sh;
  logic [DCNT_W-1:0] div_cnt;
  logic              eof_q;

  // window walk
  logic [gbd_pkg::KIDX_W-1:0] dy, dx;
  logic [ADDR_W-1:0]          addr_q;
  logic [ADDR_W:0]            addr_step;
  logic                       tap_ok;
  logic [SLOT_W:0]            rr_sum;
  logic [LINE_W:0]            cc_sum;

  // multiply-accumulate pipeline
  logic                         p1_v, p2_v, ok1;
  logic [gbd_pkg::WGT_W-1:0]    w1;
  logic [gbd_pkg::PROD_W-1:0]   prod;
  logic [gbd_pkg::ACC_W-1:0]    acc;
  logic [gbd_pkg::PIX_W-1:0]    rd_data, sat_pix;

  // memory port
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
  logic [gbd_pkg::PIX_W-1:0] mem_wdata;

  function automatic logic [gbd_pkg::TAP_W-1:0] tap_sel(
    input logic [gbd_pkg::KIDX_W-1:0] i,
    input logic [gbd_pkg::TAP_W-1:0]  t_out,
    input logic [gbd_pkg::TAP_W-1:0]  t_in,
    input logic [gbd_pkg::TAP_W-1:0]  t_ctr
  );
    logic [gbd_pkg::KIDX_W-1:0] d;
    d = (i < gbd_pkg::KIDX_W'(gbd_pkg::HALF_K)) ? gbd_pkg::KIDX_W'(gbd_pkg::HALF_K) - i
                                                : i - gbd_pkg::KIDX_W'(gbd_pkg::HALF_K);
    if (d == '0) return t_ctr;
    if (d == gbd_pkg::KIDX_W'(1)) return t_in;
    return t_out;
  endfunction

  gbd_ram #(
    .WIDTH (gbd_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width     <= gbd_pkg::FRAME_WIDTH_RST;
      frame_height    <= gbd_pkg::FRAME_HEIGHT_RST;
      decimate_enable <= 1'b0;
      tap_outer       <= gbd_pkg::TAP_OUTER_RST;
      tap_inner       <= gbd_pkg::TAP_INNER_RST;
      tap_center      <= gbd_pkg::TAP_CENTER_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        gbd_pkg::REG_FRAME_WIDTH:  frame_width     <= cfg_data[gbd_pkg::COL_W-1:0];
        gbd_pkg::REG_FRAME_HEIGHT: frame_height    <= cfg_data[gbd_pkg::ROW_W-1:0];
        gbd_pkg::REG_DECIMATE:     decimate_enable <= cfg_data[0];
        gbd_pkg::REG_TAP_OUTER:    tap_outer       <= cfg_data;
        gbd_pkg::REG_TAP_INNER:    tap_inner       <= cfg_data;
        gbd_pkg::REG_TAP_CENTER:   tap_center      <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp frame sizes
  always_comb begin
    w_clamp = CLMP_W'(frame_width);
    if (w_clamp < CLMP_W'(gbd_pkg::MIN_SIZE)) w_clamp = CLMP_W'(gbd_pkg::MIN_SIZE);
    if (w_clamp > CLMP_W'(MAX_LINE))          w_clamp = CLMP_W'(MAX_LINE);
    h_clamp = CLMP_W'(frame_height);
    if (h_clamp < CLMP_W'(gbd_pkg::MIN_SIZE))   h_clamp = CLMP_W'(gbd_pkg::MIN_SIZE);
    if (h_clamp > CLMP_W'(gbd_pkg::MAX_HEIGHT)) h_clamp = CLMP_W'(gbd_pkg::MAX_HEIGHT);
  end

  // geometry, sampled while idle or clearing so the product is registered
  always_ff @(posedge clk) begin
    if (state == gbd_pkg::S_IDLE || state == gbd_pkg::S_CLEAR) begin
      w_q     <= LINE_W'(w_clamp);
      h_q     <= gbd_pkg::ROW_W'(h_clamp);
      ow_q    <= decimate_enable ? LINE_W'(w_clamp >> 1) : LINE_W'(w_clamp);
      oh_q    <= decimate_enable ? gbd_pkg::ROW_W'(h_clamp >> 1)
                                 : gbd_pkg::ROW_W'(h_clamp);
      total_q <= (decimate_enable ? TOT_W'(w_clamp >> 1) : TOT_W'(w_clamp)) *
                 (decimate_enable ? TOT_W'(h_clamp >> 1) : TOT_W'(h_clamp));
      delay_q <= (decimate_enable ? DLY_W'(w_clamp >> 1) : DLY_W'(w_clamp)) * DLY_W'(2)
                 + DLY_W'(2);
    end
  end

  // per-request stream decisions
  always_comb begin
    start_new = !drain_q && input_done;
    col_e     = start_new ? '0 : column_count;
    row_e     = start_new ? '0 : row_count;
    slot_e    = start_new ? '0 : slot_count;
    smod_e    = start_new ? '0 : slot_mod;
    keep      = !decimate_enable || (row_e[0] && col_e[0]);
    push      = drain_q ? (input_done &&
                           ((SLOT_W+1)'(slot_count) < (SLOT_W+1)'(total_q) + (SLOT_W+1)'(delay_q)))
                        : keep;
    slot_n    = slot_e + SLOT_W'(1);
    smod_n    = (smod_e == ADDR_W'(DEPTH - 1)) ? '0 : smod_e + ADDR_W'(1);
    k_n       = slot_n - SLOT_W'(1) - SLOT_W'(delay_q);
    res_hit   = push && (slot_n > SLOT_W'(delay_q)) && (k_n < SLOT_W'(total_q));
    last_col  = (CLMP_W'(col_e) + CLMP_W'(1)) >= CLMP_W'(w_q);
    last_row  = (CLMP_W'(row_e) + CLMP_W'(1)) >= CLMP_W'(h_q);
    // top-left window entry: slot index minus one minus twice the delay
    back_n    = (ADDR_W+1)'(delay_q) * (ADDR_W+1)'(2) + (ADDR_W+1)'(1);
    if ((ADDR_W+1)'(smod_n) >= back_n) begin
      base_addr = (ADDR_W+1)'(smod_n) - back_n;
    end else begin
      base_addr = (ADDR_W+1)'(smod_n) + (ADDR_W+1)'(DEPTH) - back_n;
    end
  end

  // window tap validity and address walk
  always_comb begin
    rr_sum = (SLOT_W+1)'(div_num) + (SLOT_W+1)'(dy);
    cc_sum = (LINE_W+1)'(rem) + (LINE_W+1)'(dx);
    tap_ok = (rr_sum >= (SLOT_W+1)'(gbd_pkg::HALF_K)) &&
             (rr_sum < (SLOT_W+1)'(oh_q) + (SLOT_W+1)'(gbd_pkg::HALF_K)) &&
             (cc_sum >= (LINE_W+1)'(gbd_pkg::HALF_K)) &&
             (cc_sum < (LINE_W+1)'(ow_q) + (LINE_W+1)'(gbd_pkg::HALF_K));
    if (dx == gbd_pkg::KIDX_W'(KLAST)) begin
      // next row start, wrapping below zero when the row start wrapped
      addr_step = (ADDR_W+1)'(addr_q) + (ADDR_W+1)'(ow_q);
      if (addr_step < (ADDR_W+1)'(KLAST)) begin
        addr_step = addr_step + (ADDR_W+1)'(DEPTH - KLAST);
      end else begin
        addr_step = addr_step - (ADDR_W+1)'(KLAST);
      end
    end else begin
      addr_step = (ADDR_W+1)'(addr_q) + (ADDR_W+1)'(1);
    end
    if (addr_step >= (ADDR_W+1)'(DEPTH)) addr_step = addr_step - (ADDR_W+1)'(DEPTH);
    rem_sh = {rem, div_num[SLOT_W-1]};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      gbd_pkg::S_CLEAR: if (clr_addr == ADDR_W'(DEPTH - 1)) state_next = gbd_pkg::S_IDLE;
      gbd_pkg::S_IDLE:  if (pixel_valid) state_next = gbd_pkg::S_STEP;
      gbd_pkg::S_STEP:  state_next = res_hit ? gbd_pkg::S_DIV : gbd_pkg::S_IDLE;
      gbd_pkg::S_DIV:   if (div_cnt == DCNT_W'(SLOT_W - 1)) state_next = gbd_pkg::S_ACC;
      gbd_pkg::S_ACC: begin
        if (dy == gbd_pkg::KIDX_W'(KLAST) && dx == gbd_pkg::KIDX_W'(KLAST)) begin
          state_next = gbd_pkg::S_WAIT;
        end
      end
      gbd_pkg::S_WAIT:  if (!p1_v && !p2_v) state_next = gbd_pkg::S_OUT;
      gbd_pkg::S_OUT:   if (!result_valid || !result_stall) state_next = gbd_pkg::S_IDLE;
      default:          state_next = gbd_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pixel_stall = (state != gbd_pkg::S_IDLE);
    mem_we      = 1'b0;
    mem_waddr   = smod_e;
    mem_wdata   = px_q;
    mem_raddr   = addr_q;
    case (state)
      gbd_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      gbd_pkg::S_STEP: mem_we = !drain_q && keep;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbd_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == gbd_pkg::S_CLEAR) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (state == gbd_pkg::S_IDLE && pixel_valid) begin
      px_q    <= pixel_data.pixel_in;
      drain_q <= pixel_data.drain;
    end
  end

  // raster and slot counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      slot_count   <= '0;
      slot_mod     <= '0;
      input_done   <= 1'b0;
    end else if (state == gbd_pkg::S_STEP) begin
      if (!drain_q) begin
        if (last_col) begin
          column_count <= '0;
          row_count    <= last_row ? '0 : row_e + gbd_pkg::ROW_W'(1);
          input_done   <= last_row;
        end else begin
          column_count <= col_e + gbd_pkg::COL_W'(1);
          row_count    <= row_e;
          input_done   <= 1'b0;
        end
      end
      if (push) begin
        slot_count <= slot_n;
        slot_mod   <= smod_n;
      end else begin
        slot_count <= slot_e;
        slot_mod   <= smod_e;
      end
    end
  end

  // divider and window walk
  always_ff @(posedge clk) begin
    case (state)
      gbd_pkg::S_STEP: begin
        div_num <= k_n;
        rem     <= '0;
        div_cnt <= '0;
        eof_q   <= (k_n == SLOT_W'(total_q) - SLOT_W'(1));
        addr_q  <= ADDR_W'(base_addr);
        dy      <= '0;
        dx      <= '0;
      end
      gbd_pkg::S_DIV: begin
        div_cnt <= div_cnt + DCNT_W'(1);
        if (rem_sh >= (LINE_W+1)'(ow_q)) begin
          rem     <= LINE_W'(rem_sh - (LINE_W+1)'(ow_q));
          div_num <= {div_num[SLOT_W-2:0], 1'b1};
        end else begin
          rem     <= LINE_W'(rem_sh);
          div_num <= {div_num[SLOT_W-2:0], 1'b0};
        end
      end
      gbd_pkg::S_ACC: begin
        addr_q <= ADDR_W'(addr_step);
        if (dx == gbd_pkg::KIDX_W'(KLAST)) begin
          dx <= '0;
          dy <= dy + gbd_pkg::KIDX_W'(1);
        end else begin
          dx <= dx + gbd_pkg::KIDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // weight, product and sum stages
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_v <= 1'b0;
      p2_v <= 1'b0;
    end else begin
      p1_v <= (state == gbd_pkg::S_ACC);
      p2_v <= p1_v;
    end
  end

  always_ff @(posedge clk) begin
    w1   <= tap_sel(dy, tap_outer, tap_inner, tap_center) *
            tap_sel(dx, tap_outer, tap_inner, tap_center);
    ok1  <= tap_ok;
    prod <= w1 * (ok1 ? rd_data : gbd_pkg::PIX_W'(0));
    if (state == gbd_pkg::S_STEP) begin
      acc <= '0;
    end else if (p2_v) begin
      acc <= acc + gbd_pkg::ACC_W'(prod);
    end
  end

  // truncate and saturate
  assign sat_pix = (acc[gbd_pkg::ACC_W-1:gbd_pkg::WGT_W+gbd_pkg::PIX_W] != '0)
                   ? '1 : acc[gbd_pkg::WGT_W +: gbd_pkg::PIX_W];

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == gbd_pkg::S_OUT && (!result_valid || !result_stall)) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gbd_pkg::S_OUT && (!result_valid || !result_stall)) begin
      result_data.pixel_out    <= sat_pix;
      result_data.end_of_frame <= eof_q;
    end
  end

  // checks
  a_write_only_step_or_clear: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == gbd_pkg::S_STEP || state == gbd_pkg::S_CLEAR))
    else $error("line store written outside store update or clearing");

  a_rem_below_width: assert property (@(posedge clk) disable iff (rst)
    (state == gbd_pkg::S_ACC) |-> (rem < ow_q))
    else $error("divider remainder not below output width");

  a_pipe_empty_at_out: assert property (@(posedge clk) disable iff (rst)
    (state == gbd_pkg::S_OUT) |-> (!p1_v && !p2_v))
    else $error("result taken before sum complete");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == gbd_pkg::S_OUT))
    else $error("result raised outside output state");

endmodule

// ----- sv/gbd_ram.sv -----
// ----------------------------------------------------------------------------
// gbd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2056
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 5x5 blur / decimate unit. Pixel frames of many
// sizes and tap settings are pushed through the unit, and each result is
// compared with an in-bench predictor of the blur, the decimation and the
// flush logic.
// ----------------------------------------------------------------------------
module tb;
  import gbd_pkg::*;

  localparam int STORE_DEPTH = 4 * MAX_LINE_DEF + 8;
  localparam int IDLE_WAIT   = 200;
  localparam int WDOG_LIMIT  = 20000;
  localparam int ITEM_GOAL   = 1400;

  logic                clk;
  logic                rst;
  logic                pixel_valid;
  logic                pixel_stall;
  pix_req_t            pixel_data;
  logic                result_valid;
  logic                result_stall;
  res_req_t            result_data;
  logic                cfg_write;
  logic [CIDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]    cfg_data;

  // predictor copy of registers and state
  logic [COL_W-1:0]    p_width;
  logic [ROW_W-1:0]    p_height;
  logic                p_decim;
  logic [TAP_W-1:0]    p_outer, p_inner, p_center;
  logic [PIX_W-1:0]    kept_px [STORE_DEPTH];
  int unsigned         col_cnt, row_cnt, slot_cnt;
  bit                  frame_in_done;

  res_req_t            blurred_q[$];
  int                  mismatches = 0;
  int                  items_sent;
  int                  results_seen = 0;
  int                  frames_run;
  int                  idle_cycles;
  bit                  quiet;
  bit                  hold_req;
  bit                  hold_done;
  int                  hold_cnt;

  typedef struct {
    logic [PIX_W-1:0] px;
    bit               drn;
    bit               known;
    logic [PIX_W-1:0] exp_px;
    bit               exp_eof;
  } dir_row_t;

  dir_row_t dir_tab [26];

  gaussian_blur_5x5_decimate_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel_data   (pixel_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint unsigned tap_wt(int i);
    int d;
    d = (i < HALF_K) ? HALF_K - i : i - HALF_K;
    if (d == 0) return longint'(p_center);
    if (d == 1) return longint'(p_inner);
    return longint'(p_outer);
  endfunction

  // predicted blur for one accepted request; returns 1 when a result is due
  function automatic bit blur_predict(input logic [PIX_W-1:0] px, input bit drn,
                                      output res_req_t r);
    int unsigned       w, h, ow, oh, total, dly, k;
    int                rr, cc, rw, cl;
    bit                push, keep;
    longint unsigned   acc;
    logic [PIX_W-1:0]  v;
    w     = clamp_size(p_width, MIN_SIZE, MAX_LINE_DEF);
    h     = clamp_size(p_height, MIN_SIZE, MAX_HEIGHT);
    ow    = p_decim ? w / 2 : w;
    oh    = p_decim ? h / 2 : h;
    total = ow * oh;
    dly   = HALF_K * ow + HALF_K;
    push  = 0;
    r     = '0;
    if (!drn) begin
      if (frame_in_done) begin
        frame_in_done = 0;
        slot_cnt = 0;
        col_cnt  = 0;
        row_cnt  = 0;
      end
      keep = !p_decim || (row_cnt[0] && col_cnt[0]);
      if (keep) begin
        kept_px[slot_cnt % STORE_DEPTH] = px;
        push = 1;
      end
      if (col_cnt + 1 >= w) begin
        col_cnt = 0;
        if (row_cnt + 1 >= h) begin
          row_cnt = 0;
          frame_in_done = 1;
        end else begin
          row_cnt++;
        end
      end else begin
        col_cnt++;
      end
    end else if (frame_in_done && slot_cnt < total + dly) begin
      push = 1;
    end
    if (!push) return 0;
    slot_cnt++;
    if (slot_cnt <= dly) return 0;
    k = slot_cnt - 1 - dly;
    if (k >= total) return 0;
    rw  = k / ow;
    cl  = k % ow;
    acc = 0;
    for (int dy = 0; dy < KERNEL_SIZE; dy++) begin
      for (int dx = 0; dx < KERNEL_SIZE; dx++) begin
        rr = rw + dy - HALF_K;
        cc = cl + dx - HALF_K;
        v  = '0;
        if (rr >= 0 && rr < int'(oh) && cc >= 0 && cc < int'(ow))
          v = kept_px[(rr * ow + cc) % STORE_DEPTH];
        acc += tap_wt(dy) * tap_wt(dx) * longint'(v);
      end
    end
    acc = acc >> 32;
    r.pixel_out    = (acc > 255) ? 8'd255 : acc[7:0];
    r.end_of_frame = (k == total - 1);
    return 1;
  endfunction

  // sender gaps
  task automatic sender_gap();
    if (!quiet) begin
      while ($urandom_range(99) < 12) begin
        pixel_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // offer one request, wait for acceptance, then predict
  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit drn,
                            input bit known, input logic [PIX_W-1:0] ep, input bit eeof);
    res_req_t r;
    bit       got;
    sender_gap();
    pixel_valid           <= 1'b1;
    pixel_data.pixel_in   <= px;
    pixel_data.drain      <= drn;
    do @(posedge clk); while (pixel_stall);
    items_sent++;
    got = blur_predict(px, drn, r);
    if (got) begin
      if (known) begin
        r.pixel_out    = ep;
        r.end_of_frame = eeof;
      end
      blurred_q.push_back(r);
    end
  endtask

  // let the unit settle before a register write
  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  // write all six registers on consecutive cycles
  task automatic program_regs(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input bit d, input logic [CFG_W-1:0] to,
                              input logic [CFG_W-1:0] ti, input logic [CFG_W-1:0] tc);
    reg_idx_t          idx [6];
    logic [CFG_W-1:0]  val [6];
    idx = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_DECIMATE,
            REG_TAP_OUTER, REG_TAP_INNER, REG_TAP_CENTER};
    val = '{w, h, CFG_W'(d), to, ti, tc};
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      case (idx[i])
        REG_FRAME_WIDTH:  p_width  = val[i][COL_W-1:0];
        REG_FRAME_HEIGHT: p_height = val[i][ROW_W-1:0];
        REG_DECIMATE:     p_decim  = val[i][0];
        REG_TAP_OUTER:    p_outer  = val[i];
        REG_TAP_INNER:    p_inner  = val[i];
        REG_TAP_CENTER:   p_center = val[i];
        default: ;
      endcase
    end
    cfg_write <= 1'b0;
  endtask

  // one frame of random pixels, optional noise and a drain tail
  task automatic run_frame(input int unsigned n_px, input int unsigned n_drain,
                           input bit noisy);
    for (int unsigned i = 0; i < n_px; i++) begin
      if (noisy && $urandom_range(99) < 5)
        send_pixel(8'($urandom), 1'b1, 0, '0, 0);
      send_pixel(8'($urandom), 1'b0, 0, '0, 0);
    end
    for (int unsigned i = 0; i < n_drain; i++)
      send_pixel(8'($urandom), 1'b1, 0, '0, 0);
    frames_run++;
  endtask

  function automatic int unsigned drain_need();
    int unsigned w, h, ow;
    w  = clamp_size(p_width, MIN_SIZE, MAX_LINE_DEF);
    h  = clamp_size(p_height, MIN_SIZE, MAX_HEIGHT);
    ow = p_decim ? w / 2 : w;
    return HALF_K * ow + HALF_K;
  endfunction

  // receiver stall, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      hold_done    <= 1'b0;
      hold_cnt     <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done    <= 1'b1;
      hold_cnt     <= 400;
      result_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= quiet ? 1'b0 : ($urandom_range(99) < 12);
    end
  end

  // result checker
  always @(posedge clk) begin
    res_req_t e;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (blurred_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pixel_out=%0d eof=%0b",
                   result_data.pixel_out, result_data.end_of_frame);
      end else begin
        e = blurred_q.pop_front();
        if (result_data.pixel_out !== e.pixel_out ||
            result_data.end_of_frame !== e.end_of_frame) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pixel_out exp %0d got %0d, eof exp %0b got %0b",
                     e.pixel_out, result_data.pixel_out,
                     e.end_of_frame, result_data.end_of_frame);
        end
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned w, h, nd;
    bit          dec;
    logic [CFG_W-1:0] to, ti, tc;
    pixel_valid <= 1'b0;
    pixel_data  <= '0;
    cfg_write   <= 1'b0;
    cfg_index   <= REG_FRAME_WIDTH;
    cfg_data    <= '0;
    rst         <= 1'b1;
    items_sent   = 0;
    frames_run   = 0;
    quiet        = 0;
    hold_req     = 0;
    p_width  = FRAME_WIDTH_RST;
    p_height = FRAME_HEIGHT_RST;
    p_decim  = 1'b0;
    p_outer  = TAP_OUTER_RST;
    p_inner  = TAP_INNER_RST;
    p_center = TAP_CENTER_RST;
    foreach (kept_px[i]) kept_px[i] = '0;
    col_cnt = 0; row_cnt = 0; slot_cnt = 0; frame_in_done = 0;

    // directed table: early drain, then a 5x5 frame, bright but for its first pixel, that saturates
    dir_tab[0] = '{8'hff, 1'b1, 1'b0, 8'd0, 1'b0};
    dir_tab[1] = '{8'h00, 1'b0, 1'b1, 8'd255, 1'b0};
    for (int i = 2; i < 26; i++) dir_tab[i] = '{8'hff, 1'b0, 1'b1, 8'd255, 1'b0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // sizes below the minimum clamp up to 5x5, max taps
    program_regs(CFG_W'(3), CFG_W'(2), 1'b0, 16'hffff, 16'hffff, 16'hffff);
    foreach (dir_tab[i])
      send_pixel(dir_tab[i].px, dir_tab[i].drn, dir_tab[i].known,
                 dir_tab[i].exp_px, dir_tab[i].exp_eof);
    // drain tail, with surplus drains that are ignored
    for (int i = 0; i < 15; i++) send_pixel(8'h00, 1'b1, 0, '0, 0);
    frames_run++;

    // tallest frame, left unfinished, then reconfigured mid-frame
    wait_idle();
    program_regs(CFG_W'(5), CFG_W'(4096), 1'b0, 16'd0, 16'd0, 16'hffff);
    run_frame(40, 0, 0);
    wait_idle();
    program_regs(CFG_W'(7), CFG_W'(6), 1'b0, TAP_OUTER_RST, TAP_INNER_RST, TAP_CENTER_RST);
    run_frame(10, 0, 0);
    run_frame(0, drain_need() + 2, 0);

    // widest line, clamped from above, decimated, left unfinished past one row
    wait_idle();
    program_regs(CFG_W'(1023), CFG_W'(5), 1'b1, 16'h8000, 16'h7fff, 16'hffff);
    run_frame(560, 0, 1);

    // random frames
    while (items_sent < ITEM_GOAL || frames_run < 12) begin
      wait_idle();
      dec = $urandom_range(1);
      w   = dec ? $urandom_range(10, 13) : $urandom_range(5, 9);
      h   = dec ? $urandom_range(10, 12) : $urandom_range(5, 7);
      case ($urandom_range(9))
        0:       begin to = 16'h0000; ti = 16'h0000; tc = 16'h0000; end
        1:       begin to = 16'hffff; ti = 16'hffff; tc = 16'hffff; end
        default: begin to = 16'($urandom); ti = 16'($urandom); tc = 16'($urandom); end
      endcase
      program_regs(CFG_W'(w), CFG_W'(h), dec, to, ti, tc);
      quiet = (frames_run >= 8 && frames_run < 11);
      if (frames_run == 5) hold_req = 1;
      nd = drain_need();
      // now and then cut the drain short so the next frame flushes it
      if ($urandom_range(9) == 0) nd = $urandom_range(0, nd - 1);
      else nd = nd + $urandom_range(0, 3);
      run_frame(w * h, nd, 1);
    end

    pixel_valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
    $display("covered %0d frames, %0d requests in, %0d blurred pixels out",
             frames_run, items_sent, results_seen);
    $display("sizes from clamped minimum to widest line, both modes, flushes and stalls");
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- gaussian_blur_5x5_decimate_unit.f -----
sv/gbd_pkg.sv
sv/gbd_ram.sv
sv/gaussian_blur_5x5_decimate_unit.sv
tb/tb.sv
